FILE: design/mwbd_pkg.sv
// Shared types and constants of the multi-revolution weak bit detector.
package mwbd_pkg;

   // Byte and counter geometry
   localparam int BITS_PER_BYTE = 8;
   localparam int REV_W         = 5;
   localparam int COUNT_W       = 5;
   localparam int THR_W         = 17;
   localparam int FRAC_W        = 16;
   localparam int TOTAL_W       = 17;
   localparam int MAX_REVS_VAL  = 16;
   localparam int MINOR_W       = $clog2(MAX_REVS_VAL / 2 + 1);
   localparam int PROD_W        = THR_W + REV_W;
   localparam int POP_W         = $clog2(BITS_PER_BYTE + 1);

   localparam logic [REV_W-1:0]   MIN_REVS        = REV_W'(2);
   localparam logic [REV_W-1:0]   MAX_REVS        = REV_W'(MAX_REVS_VAL);
   localparam logic [REV_W-1:0]   REVS_RESET      = REV_W'(2);
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(6554);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};

   // Register indexes of the CSR port
   typedef enum logic [0:0] {
      CSR_REVOLUTIONS = 1'b0,
      CSR_THRESHOLD   = 1'b1
   } csr_index_type;

   // One completed byte position, handed from front to back
   typedef struct packed {
      logic [BITS_PER_BYTE-1:0][COUNT_W-1:0] ones;
      logic [REV_W-1:0]                      taken;
      logic                                  last;
   } entry_type;

   // Queue status seen by the top level and the back end
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: design/multirev_weak_bit_detector.sv
// Multi-revolution weak bit detector, top level.
// Takes one revolution byte per cycle on the req_ stream, grouped by byte position in
// revolution order; after the byte that completes a position (revolutions bytes, clamped
// to 2..16) it returns one word carrying the weak bit mask, the saturating weak bit total
// of the track, and tlast when the completing byte had tlast set (the total then restarts
// at zero). A bit is weak when its minority count across revolutions, as a fraction of the
// revolutions taken, reaches the Q1.16 threshold. Sustained rate is one byte per cycle
// while the result stream does not stall: the per-bit counters in the front end take a
// byte every cycle, and the back end runs one registered multiply stage and one registered
// compare stage per position, after the queue slot. A queue of QUEUE_DEPTH positions
// between the front and back ends absorbs output stalls before req_tready drops. The CSR
// port takes a write in any cycle; write it only while no result is pending, since the
// threshold is applied to a position when the back end picks it up.
module multirev_weak_bit_detector #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rev_byte
   input  logic        req_tlast,   // last_of_track
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] flag_mask, [24:8] weak_total, [31:25] zero
   output logic        rsp_tlast,   // track_done
   // CSR write port
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   logic [mwbd_pkg::REV_W-1:0]          revolutions_ff;
   logic [mwbd_pkg::THR_W-1:0]          threshold_ff;
   logic                                req_accept;
   logic                                push;
   mwbd_pkg::entry_type                 push_entry;
   mwbd_pkg::entry_type                 pop_entry;
   logic                                pop;
   mwbd_pkg::queue_status_type          status;
   logic [mwbd_pkg::BITS_PER_BYTE-1:0]  flag_mask;
   logic [mwbd_pkg::TOTAL_W-1:0]        weak_total;

   // CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         revolutions_ff <= mwbd_pkg::REVS_RESET;
         threshold_ff   <= mwbd_pkg::THRESHOLD_RESET;
      end else if (csr_wen) begin
         if (csr_index == mwbd_pkg::CSR_REVOLUTIONS) begin
            revolutions_ff <= csr_wdata[mwbd_pkg::REV_W-1:0];
         end else if (csr_index == mwbd_pkg::CSR_THRESHOLD) begin
            threshold_ff <= csr_wdata[mwbd_pkg::THR_W-1:0];
         end
      end
   end

   assign req_tready = !status.full;
   assign req_accept = req_tvalid && req_tready;

   mwbd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .revolutions   (revolutions_ff),
      .accept        (req_accept),
      .rev_byte      (req_tdata),
      .last_of_track (req_tlast),
      .push          (push),
      .entry         (push_entry)
   );

   mwbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (status)
   );

   mwbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .entry      (pop_entry),
      .status     (status),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .flag_mask  (flag_mask),
      .weak_total (weak_total),
      .track_done (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, weak_total, flag_mask};

   // Queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("position queue overflow");

   // Queue never read while empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("position queue underflow");

   // Total always covers the bits flagged in the current mask
   a_total_covers_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (weak_total >= mwbd_pkg::TOTAL_W'($countones(flag_mask))))
      else $error("weak total below mask bit count");

   // No result right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

FILE: design/mwbd_front.sv
// Front end: per-bit one counters across revolutions, emits completed positions.
module mwbd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mwbd_pkg::REV_W-1:0]          revolutions,
   input  logic                                accept,
   input  logic [mwbd_pkg::BITS_PER_BYTE-1:0]  rev_byte,
   input  logic                                last_of_track,
   output logic                                push,
   output mwbd_pkg::entry_type                 entry
);

   logic [mwbd_pkg::BITS_PER_BYTE-1:0][mwbd_pkg::COUNT_W-1:0] ones_ff, ones_in, ones_sum;
   logic [mwbd_pkg::REV_W-1:0] rev_index_ff, rev_index_in;
   logic [mwbd_pkg::REV_W-1:0] eff_revs;
   logic [mwbd_pkg::REV_W-1:0] taken;
   logic                       complete;

   // Clamp the revolution count to the supported range
   always_comb begin
      priority if (revolutions < mwbd_pkg::MIN_REVS) begin
         eff_revs = mwbd_pkg::MIN_REVS;
      end else if (revolutions > mwbd_pkg::MAX_REVS) begin
         eff_revs = mwbd_pkg::MAX_REVS;
      end else begin
         eff_revs = revolutions;
      end
   end

   // Counter update and completion check
   always_comb begin
      for (int k = 0; k < mwbd_pkg::BITS_PER_BYTE; k++) begin
         ones_sum[k] = ones_ff[k] + mwbd_pkg::COUNT_W'(rev_byte[k]);
      end
      taken    = rev_index_ff + mwbd_pkg::REV_W'(1);
      complete = (taken >= eff_revs);

      ones_in      = ones_ff;
      rev_index_in = rev_index_ff;
      if (accept) begin
         if (complete) begin
            ones_in      = '0;
            rev_index_in = '0;
         end else begin
            ones_in      = ones_sum;
            rev_index_in = taken;
         end
      end
   end

   assign push        = accept && complete;
   assign entry.ones  = ones_sum;
   assign entry.taken = taken;
   assign entry.last  = last_of_track;

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff      <= '0;
         rev_index_ff <= '0;
      end else begin
         ones_ff      <= ones_in;
         rev_index_ff <= rev_index_in;
      end
   end

endmodule

FILE: design/mwbd_queue.sv
// Short queue of completed byte positions between front and back ends.
module mwbd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  mwbd_pkg::entry_type          push_entry,
   input  logic                         pop,
   output mwbd_pkg::entry_type          pop_entry,
   output mwbd_pkg::queue_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mwbd_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign pop_entry    = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/mwbd_back.sv
// Back end: minority counts, threshold compare, weak mask and running total.
module mwbd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mwbd_pkg::THR_W-1:0]          threshold,
   input  mwbd_pkg::entry_type                 entry,
   input  mwbd_pkg::queue_status_type          status,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mwbd_pkg::BITS_PER_BYTE-1:0]  flag_mask,
   output logic [mwbd_pkg::TOTAL_W-1:0]        weak_total,
   output logic                                track_done
);

   localparam int PAD_W = mwbd_pkg::PROD_W - mwbd_pkg::MINOR_W - mwbd_pkg::FRAC_W;

   // Stage A: threshold product and minority counts
   logic                                                       a_valid_ff, a_valid_in;
   logic [mwbd_pkg::PROD_W-1:0]                                a_prod_ff, a_prod_in;
   logic [mwbd_pkg::BITS_PER_BYTE-1:0][mwbd_pkg::MINOR_W-1:0]  a_minor_ff, a_minor_in;
   logic                                                       a_last_ff;

   // Output stage
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [mwbd_pkg::BITS_PER_BYTE-1:0]    mask_ff, mask_in;
   logic [mwbd_pkg::TOTAL_W-1:0]          total_ff, total_in;
   logic                                  done_ff;
   logic [mwbd_pkg::TOTAL_W-1:0]          running_ff, running_in;

   logic                                  out_load_ok;
   logic                                  a_load_ok;
   logic                                  out_load;
   logic [mwbd_pkg::POP_W-1:0]            weak_cnt;
   logic [mwbd_pkg::TOTAL_W:0]            total_sum;
   logic [mwbd_pkg::COUNT_W-1:0]          ones_c;
   logic [mwbd_pkg::COUNT_W-1:0]          zeros_c;
   logic [mwbd_pkg::COUNT_W-1:0]          minor_c;

   // Pipeline handshake
   assign out_load_ok  = !rsp_valid_ff || rsp_ready;
   assign a_load_ok    = !a_valid_ff || out_load_ok;
   assign pop          = a_load_ok && !status.empty;
   assign out_load     = out_load_ok && a_valid_ff;
   assign a_valid_in   = a_load_ok ? !status.empty : a_valid_ff;
   assign rsp_valid_in = out_load_ok ? a_valid_ff : rsp_valid_ff;

   // Minority count per bit and threshold times revolutions taken
   always_comb begin
      ones_c  = '0;
      zeros_c = '0;
      minor_c = '0;
      for (int k = 0; k < mwbd_pkg::BITS_PER_BYTE; k++) begin
         ones_c        = (entry.ones[k] > entry.taken) ? entry.taken : entry.ones[k];
         zeros_c       = entry.taken - ones_c;
         minor_c       = (ones_c < zeros_c) ? ones_c : zeros_c;
         a_minor_in[k] = minor_c[mwbd_pkg::MINOR_W-1:0];
      end
      a_prod_in = mwbd_pkg::PROD_W'(threshold) * mwbd_pkg::PROD_W'(entry.taken);
   end

   // Compare, mask, and saturating track total
   always_comb begin
      weak_cnt = '0;
      for (int k = 0; k < mwbd_pkg::BITS_PER_BYTE; k++) begin
         mask_in[k] = ({{PAD_W{1'b0}}, a_minor_ff[k], {mwbd_pkg::FRAC_W{1'b0}}} >= a_prod_ff);
         weak_cnt   = weak_cnt + mwbd_pkg::POP_W'(mask_in[k]);
      end
      total_sum = {1'b0, running_ff} + (mwbd_pkg::TOTAL_W + 1)'(weak_cnt);
      total_in  = total_sum[mwbd_pkg::TOTAL_W] ? mwbd_pkg::TOTAL_MAX
                                               : total_sum[mwbd_pkg::TOTAL_W-1:0];
      running_in = running_ff;
      if (out_load) begin
         running_in = a_last_ff ? '0 : total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         running_ff   <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         a_prod_ff  <= a_prod_in;
         a_minor_ff <= a_minor_in;
         a_last_ff  <= entry.last;
      end
      if (out_load) begin
         mask_ff  <= mask_in;
         total_ff <= total_in;
         done_ff  <= a_last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign flag_mask  = mask_ff;
   assign weak_total = total_ff;
   assign track_done = done_ff;

endmodule
